// ----- design/asa_pkg.sv -----
// Shared widths, codes and the arithmetic unit opcode for the aligned stack allocator.
// No dependencies; every other design file depends on this package.
package asa_pkg;

    localparam int CMD_W      = 2;
    localparam int SIZE_W     = 17;
    localparam int ALIGN_W    = 8;
    localparam int FADDR_W    = 16;
    localparam int OADDR_W    = 16;
    localparam int STATUS_W   = 2;
    localparam int USED_W     = 17;
    localparam int LIVE_W     = 7;
    localparam int ADJ_W      = 8;
    localparam int BASE_W     = 16;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 1;

    // commands
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_SIZE = 1'd1;

    // reset capacity of the region
    localparam logic [CFG_DATA_W-1:0] REGION_SIZE_RESET = 17'h10000;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

endpackage

// ----- design/asa_channels.sv -----
// Valid/ready channel interfaces for the request and response items.
// Depends on asa_pkg for field widths.
interface asa_req_if;
    logic                          valid;
    logic                          ready;
    logic [asa_pkg::CMD_W-1:0]     cmd;
    logic [asa_pkg::SIZE_W-1:0]    req_size;
    logic [asa_pkg::ALIGN_W-1:0]   alignment;
    logic [asa_pkg::FADDR_W-1:0]   free_address;

    modport source (output valid, cmd, req_size, alignment, free_address, input ready);
    modport sink   (input valid, cmd, req_size, alignment, free_address, output ready);
endinterface

interface asa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [asa_pkg::OADDR_W-1:0]   address;
    logic [asa_pkg::STATUS_W-1:0]  status;
    logic [asa_pkg::USED_W-1:0]    used_bytes;
    logic [asa_pkg::LIVE_W-1:0]    live_count;

    modport source (output valid, address, status, used_bytes, live_count, input ready);
    modport sink   (input valid, address, status, used_bytes, live_count, output ready);
endinterface

// ----- design/asa_addsub.sv -----
// Shared add/subtract unit used by the allocator sequencer for every wide step.
// Depends on asa_pkg for the opcode type.
module asa_addsub #(
    parameter int WIDTH = 19
) (
    input  asa_pkg::alu_op_t  op,
    input  logic [WIDTH-1:0]  a,
    input  logic [WIDTH-1:0]  b,
    output logic [WIDTH-1:0]  y,
    output logic              carry
);
    import asa_pkg::*;

    logic [WIDTH:0] full;

    always_comb
    begin
        unique case (op)
            ALU_ADD: full = {1'b0, a} + {1'b0, b};
            ALU_SUB: full = {1'b0, a} - {1'b0, b};
            default: full = {1'b0, a} + {1'b0, b};
        endcase
    end

    // carry out on add, borrow (a < b) on subtract
    assign y     = full[WIDTH-1:0];
    assign carry = full[WIDTH];

endmodule

// ----- design/aligned_stack_allocator_core.sv -----
// Top level of the aligned stack allocator: sequencer, state registers and record memory.
// Depends on asa_pkg, asa_channels (req/rsp interfaces) and asa_addsub.
//
// Usage:
//   req carries one item (cmd, req_size, alignment, free_address); rsp returns one
//   item per request (address, status, used_bytes, live_count). wr_en/wr_index/wr_data
//   write region_base (index 0) and region_size (index 1); write only while idle.
//   One item at a time: req.ready is high only while the sequencer is idle.
//   Steps from accept to the result loaded in the output register, which drives rsp.valid:
//     allocate      : adjust, total, sum, fit, addr, top, done; out of memory goes from fit to done
//     free          : a memory read plus a compare for each record scanned from the top
//                     (1..depth), then restore, freed, used, done; a miss scans every
//                     live record
//     free on empty, release, unknown command : straight to done
//   All wide arithmetic goes through the single asa_addsub unit, one op a cycle, which
//   sets the allocate length; the record memory's single registered read port sets the
//   free scan rate.
//   The output register decouples the sides: a new item is accepted while a result
//   waits; a finished item holds in the done step until rsp is free.
//   Reset (async, rst_n low): empty stack, top at 0, region_base 0, region_size 65536.
//   The record memory has no reset; only entries below the live count are used.
module aligned_stack_allocator_core #(
    parameter int ADDR_BITS    = 16,
    parameter int STACK_DEPTH  = 64,
    parameter int HEADER_BYTES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [asa_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [asa_pkg::CFG_DATA_W-1:0] wr_data,
    asa_req_if.sink                       req,
    asa_rsp_if.source                     rsp
);
    import asa_pkg::*;

    localparam int POS_W = ADDR_BITS + 1;
    // unit width: positions, and used + total without overflow
    localparam int UW    = (POS_W > 19) ? POS_W : 19;
    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [UW-1:0]    ADDR_MASK_U = (UW'(1) << ADDR_BITS) - UW'(1);
    localparam logic [ADJ_W-1:0] HDR         = ADJ_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] DEPTH_C     = CNT_W'(STACK_DEPTH);

    typedef struct packed {
        logic [POS_W-1:0] aligned;
        logic [ADJ_W-1:0] adjust;
        logic [POS_W-1:0] prev;
    } rec_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADJ,
        S_TOTAL,
        S_SUM,
        S_FIT,
        S_ALIGNED,
        S_TOP,
        S_FREE_RD,
        S_FREE_CMP,
        S_RESTORE,
        S_FREED,
        S_USED,
        S_DONE
    } state_t;

    // configuration
    logic [BASE_W-1:0]     base_reg, base_next;
    logic [CFG_DATA_W-1:0] rsize_reg, rsize_next;

    // allocator state
    logic [POS_W-1:0]  top_reg, top_next;
    logic [POS_W-1:0]  prev_reg, prev_next;
    logic [USED_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // sequencer and working registers
    state_t            state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [ADJ_W-1:0]  amask_reg, amask_next;
    logic [FADDR_W-1:0] faddr_reg, faddr_next;
    logic [ADJ_W-1:0]  adj_reg, adj_next;
    logic [UW-1:0]     tot_reg, tot_next;
    logic [UW-1:0]     sum_reg, sum_next;
    logic [UW-1:0]     work_reg, work_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [OADDR_W-1:0] raddr_reg, raddr_next;
    logic [STATUS_W-1:0] rstat_reg, rstat_next;

    // output register
    logic                ovalid_reg, ovalid_next;
    logic [OADDR_W-1:0]  oaddr_reg, oaddr_next;
    logic [STATUS_W-1:0] ostat_reg, ostat_next;
    logic [USED_W-1:0]   oused_reg, oused_next;
    logic [LIVE_W-1:0]   olive_reg, olive_next;

    // record memory
    rec_t             rec_mem [STACK_DEPTH];
    rec_t             rd_data;
    rec_t             wr_rec;
    logic             mem_we;
    logic [IDX_W-1:0] wr_addr;

    // shared unit
    alu_op_t       alu_op;
    logic [UW-1:0] alu_a, alu_b, alu_y;
    logic          alu_c;

    asa_addsub #(.WIDTH(UW)) u_alu (
        .op    (alu_op),
        .a     (alu_a),
        .b     (alu_b),
        .y     (alu_y),
        .carry (alu_c)
    );

    // alignment mask from the highest set bit; zero means byte aligned
    logic [ADJ_W-1:0] in_amask;
    always_comb
    begin
        in_amask = '0;
        for (int i = 0; i < ALIGN_W; i++)
        begin
            if (req.alignment[i])
            begin
                in_amask = ADJ_W'((1 << i) - 1);
            end
        end
    end

    // forward adjustment: align the top, then step whole alignments until the
    // header fits in front of the grant
    logic [ADJ_W-1:0] adj_base, adj_need, adj_up, adj_calc;
    always_comb
    begin
        adj_base = (~top_reg[ADJ_W-1:0] + ADJ_W'(1)) & amask_reg;
        adj_need = HDR - adj_base;
        adj_up   = (adj_need + amask_reg) & ~amask_reg;
        adj_calc = (adj_base < HDR) ? (adj_base + adj_up) : adj_base;
    end

    // free lookup compares the low ADDR_BITS bits of the record
    logic          rec_hit;
    logic [UW-1:0] grant_ext;
    assign rec_hit   = (UW'(rd_data.aligned[ADDR_BITS-1:0]) == (UW'(faddr_reg) & ADDR_MASK_U));
    assign grant_ext = UW'(alu_y[ADDR_BITS-1:0]);

    // operand selection for the shared unit
    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
        unique case (state_reg)
            S_TOTAL:
            begin
                alu_a = UW'(adj_reg);
                alu_b = UW'(size_reg);
            end
            S_SUM:
            begin
                alu_a = UW'(used_reg);
                alu_b = tot_reg;
            end
            S_FIT:
            begin
                alu_op = ALU_SUB;
                alu_a  = UW'(rsize_reg);
                alu_b  = sum_reg;
            end
            S_ALIGNED:
            begin
                alu_a = UW'(top_reg);
                alu_b = UW'(adj_reg);
            end
            S_TOP:
            begin
                alu_a = UW'(top_reg);
                alu_b = tot_reg;
            end
            S_RESTORE:
            begin
                alu_op = ALU_SUB;
                alu_a  = UW'(rd_data.aligned);
                alu_b  = UW'(rd_data.adjust);
            end
            S_FREED:
            begin
                alu_op = ALU_SUB;
                alu_a  = UW'(top_reg);
                alu_b  = work_reg;
            end
            S_USED:
            begin
                alu_op = ALU_SUB;
                alu_a  = UW'(used_reg);
                alu_b  = tot_reg;
            end
            default:
            begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    assign mem_we  = (state_reg == S_ALIGNED);
    assign wr_addr = count_reg[IDX_W-1:0];
    assign wr_rec  = '{aligned: alu_y[POS_W-1:0], adjust: adj_reg, prev: prev_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rec_mem[wr_addr] <= wr_rec;
        end
        rd_data <= rec_mem[idx_reg];
    end

    // next-state logic
    always_comb
    begin
        base_next   = base_reg;
        rsize_next  = rsize_reg;
        top_next    = top_reg;
        prev_next   = prev_reg;
        used_next   = used_reg;
        count_next  = count_reg;
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        size_next   = size_reg;
        amask_next  = amask_reg;
        faddr_next  = faddr_reg;
        adj_next    = adj_reg;
        tot_next    = tot_reg;
        sum_next    = sum_reg;
        work_next   = work_reg;
        idx_next    = idx_reg;
        raddr_next  = raddr_reg;
        rstat_next  = rstat_reg;
        ovalid_next = ovalid_reg;
        oaddr_next  = oaddr_reg;
        ostat_next  = ostat_reg;
        oused_next  = oused_reg;
        olive_next  = olive_reg;

        if (wr_en)
        begin
            unique case (wr_index)
                REG_REGION_BASE: base_next  = wr_data[BASE_W-1:0];
                REG_REGION_SIZE: rsize_next = wr_data;
                default:         rsize_next = rsize_reg;
            endcase
        end

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.cmd;
                    size_next  = req.req_size;
                    amask_next = in_amask;
                    faddr_next = req.free_address;
                    raddr_next = '0;
                    rstat_next = ST_OK;
                    case (req.cmd)
                        CMD_ALLOC:
                        begin
                            state_next = S_ADJ;
                        end
                        CMD_FREE:
                        begin
                            if (count_reg == '0)
                            begin
                                rstat_next = ST_BAD_FREE;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                idx_next   = IDX_W'(count_reg - CNT_W'(1));
                                state_next = S_FREE_RD;
                            end
                        end
                        CMD_RELEASE:
                        begin
                            top_next   = POS_W'(base_reg);
                            prev_next  = '0;
                            used_next  = '0;
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ADJ:
            begin
                adj_next   = adj_calc;
                state_next = S_TOTAL;
            end
            S_TOTAL:
            begin
                tot_next   = alu_y;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                sum_next   = alu_y;
                state_next = S_FIT;
            end
            S_FIT:
            begin
                // borrow means used + total exceeds the capacity
                if (alu_c || (count_reg >= DEPTH_C))
                begin
                    rstat_next = ST_OOM;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ALIGNED;
                end
            end
            S_ALIGNED:
            begin
                raddr_next = grant_ext[OADDR_W-1:0];
                state_next = S_TOP;
            end
            S_TOP:
            begin
                prev_next  = top_reg;
                top_next   = alu_y[POS_W-1:0];
                used_next  = sum_reg[USED_W-1:0];
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end
            S_FREE_RD:
            begin
                state_next = S_FREE_CMP;
            end
            S_FREE_CMP:
            begin
                if (rec_hit)
                begin
                    state_next = S_RESTORE;
                end
                else if (idx_reg == '0)
                begin
                    rstat_next = ST_BAD_FREE;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg - IDX_W'(1);
                    state_next = S_FREE_RD;
                end
            end
            S_RESTORE:
            begin
                work_next  = UW'(alu_y[POS_W-1:0]);
                state_next = S_FREED;
            end
            S_FREED:
            begin
                tot_next   = UW'(alu_y[POS_W-1:0]);
                state_next = S_USED;
            end
            S_USED:
            begin
                // freed beyond the used count clamps to zero
                used_next  = alu_c ? '0 : alu_y[USED_W-1:0];
                top_next   = work_reg[POS_W-1:0];
                prev_next  = rd_data.prev;
                count_next = CNT_W'(idx_reg);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    oaddr_next  = raddr_reg;
                    ostat_next  = rstat_reg;
                    oused_next  = used_reg;
                    olive_next  = LIVE_W'(count_reg);
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            rsize_reg  <= REGION_SIZE_RESET;
            top_reg    <= '0;
            prev_reg   <= '0;
            used_reg   <= '0;
            count_reg  <= '0;
            state_reg  <= S_IDLE;
            cmd_reg    <= '0;
            size_reg   <= '0;
            amask_reg  <= '0;
            faddr_reg  <= '0;
            adj_reg    <= '0;
            tot_reg    <= '0;
            sum_reg    <= '0;
            work_reg   <= '0;
            idx_reg    <= '0;
            raddr_reg  <= '0;
            rstat_reg  <= ST_OK;
            ovalid_reg <= 1'b0;
            oaddr_reg  <= '0;
            ostat_reg  <= ST_OK;
            oused_reg  <= '0;
            olive_reg  <= '0;
        end
        else
        begin
            base_reg   <= base_next;
            rsize_reg  <= rsize_next;
            top_reg    <= top_next;
            prev_reg   <= prev_next;
            used_reg   <= used_next;
            count_reg  <= count_next;
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            size_reg   <= size_next;
            amask_reg  <= amask_next;
            faddr_reg  <= faddr_next;
            adj_reg    <= adj_next;
            tot_reg    <= tot_next;
            sum_reg    <= sum_next;
            work_reg   <= work_next;
            idx_reg    <= idx_next;
            raddr_reg  <= raddr_next;
            rstat_reg  <= rstat_next;
            ovalid_reg <= ovalid_next;
            oaddr_reg  <= oaddr_next;
            ostat_reg  <= ostat_next;
            oused_reg  <= oused_next;
            olive_reg  <= olive_next;
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = ovalid_reg;
    assign rsp.address    = oaddr_reg;
    assign rsp.status     = ostat_reg;
    assign rsp.used_bytes = oused_reg;
    assign rsp.live_count = olive_reg;

endmodule

// ----- bench/aligned_stack_allocator_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for aligned_stack_allocator_core: directed and random traffic with an
// item-level mirror of the allocator. Needs asa_pkg, asa_channels, asa_addsub and the core RTL.
module aligned_stack_allocator_core_tb;
    import asa_pkg::*;

    localparam int ADDR_BITS    = 16;
    localparam int STACK_DEPTH  = 64;
    localparam int HEADER_BYTES = 16;
    localparam int POS_W        = ADDR_BITS + 1;
    localparam int unsigned POS_MASK = (1 << POS_W) - 1;

    // settle at the end for longer than the worst free scan takes
    localparam int SETTLE_CYCLES = 2 * STACK_DEPTH + 16;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int IDLE_PCT      = 32;

    // the one command code the package leaves unnamed; the core ignores it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SIZE_W-1:0]  req_size;
        logic [ALIGN_W-1:0] alignment;
        logic [FADDR_W-1:0] free_address;
    } alloc_req_t;

    typedef struct packed {
        logic [OADDR_W-1:0]  address;
        logic [STATUS_W-1:0] status;
        logic [USED_W-1:0]   used_bytes;
        logic [LIVE_W-1:0]   live_count;
    } alloc_rsp_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    asa_req_if req_ch ();
    asa_rsp_if rsp_ch ();

    aligned_stack_allocator_core #(
        .ADDR_BITS    (ADDR_BITS),
        .STACK_DEPTH  (STACK_DEPTH),
        .HEADER_BYTES (HEADER_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Mirror of the allocator state. Updated when an item is accepted, so
    // it always reflects everything the core has taken so far.
    // ------------------------------------------------------------------
    logic [BASE_W-1:0]     mirror_base;
    logic [CFG_DATA_W-1:0] mirror_capacity;
    logic [POS_W-1:0]      top_pos;
    logic [POS_W-1:0]      prev_pos;
    logic [USED_W-1:0]     used_q;
    int                    live_q;
    logic [POS_W-1:0]      rec_aligned [STACK_DEPTH];
    logic [ADJ_W-1:0]      rec_adjust  [STACK_DEPTH];
    logic [POS_W-1:0]      rec_prev    [STACK_DEPTH];

    alloc_rsp_t pending_results[$];
    alloc_rsp_t oldest_result;
    int         errors;
    int         cycle_count;
    bit         idle_on;

    // back to an empty stack; top picks up whatever base is configured now
    function automatic void empty_mirror();
        top_pos  = POS_W'(mirror_base);
        prev_pos = '0;
        used_q   = '0;
        live_q   = 0;
    endfunction

    // expected result of one item, with the mirror advanced past it
    function automatic alloc_rsp_t predict_item(alloc_req_t it);
        alloc_rsp_t  r;
        int unsigned align;
        int unsigned adj;
        int unsigned need;
        int unsigned total;
        int unsigned aligned_pos;
        int unsigned restored;
        int unsigned freed;
        int          idx;
        bit          hit;
        r     = '0;
        align = 1;
        // non power of two: highest set bit wins, zero means byte alignment
        for (int b = 0; b < ALIGN_W; b++)
            if (it.alignment[b])
                align = 1 << b;
        case (it.cmd)
            CMD_ALLOC:
            begin
                adj = (align - (top_pos & (align - 1))) & (align - 1);
                // grow the pad in whole alignment steps until the header fits
                if (adj < HEADER_BYTES)
                begin
                    need = HEADER_BYTES - adj;
                    adj += align * (need / align);
                    if (need % align != 0)
                        adj += align;
                end
                total = adj + it.req_size;
                if (live_q >= STACK_DEPTH || used_q + total > mirror_capacity)
                    r.status = ST_OOM;
                else
                begin
                    aligned_pos         = (top_pos + adj) & POS_MASK;
                    rec_aligned[live_q] = POS_W'(aligned_pos);
                    rec_adjust[live_q]  = ADJ_W'(adj);
                    rec_prev[live_q]    = prev_pos;
                    prev_pos            = top_pos;
                    top_pos             = POS_W'(top_pos + total);
                    used_q              = USED_W'(used_q + total);
                    live_q++;
                    r.address           = OADDR_W'(aligned_pos);
                    r.status            = ST_OK;
                end
            end
            CMD_FREE:
            begin
                hit = 1'b0;
                idx = live_q;
                // newest record first; only the low address bits take part
                while (idx > 0 && !hit)
                begin
                    idx--;
                    if (rec_aligned[idx][ADDR_BITS-1:0] == it.free_address)
                        hit = 1'b1;
                end
                if (!hit)
                    r.status = ST_BAD_FREE;
                else
                begin
                    restored = (rec_aligned[idx] - rec_adjust[idx]) & POS_MASK;
                    freed    = (top_pos - restored) & POS_MASK;
                    used_q   = (freed > used_q) ? '0 : USED_W'(used_q - freed);
                    top_pos  = POS_W'(restored);
                    prev_pos = rec_prev[idx];
                    live_q   = idx;
                end
            end
            CMD_RELEASE:
                empty_mirror();
            default:
                ;
        endcase
        r.used_bytes = used_q;
        r.live_count = LIVE_W'(live_q);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Response side: random back-pressure, checker against oldest expectation
    // ------------------------------------------------------------------
    always @(negedge clk)
        rsp_ch.ready = idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected item: expected none actual address %0h status %0h",
                         $time, rsp_ch.address, rsp_ch.status);
                errors++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                check_field("address", oldest_result.address, rsp_ch.address);
                check_field("status", oldest_result.status, rsp_ch.status);
                check_field("used_bytes", oldest_result.used_bytes, rsp_ch.used_bytes);
                check_field("live_count", oldest_result.live_count, rsp_ch.live_count);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Present one item at a falling edge (after random idle cycles), hold it
    // until a rising edge sees ready, then record what it should produce.
    task automatic send_request(alloc_req_t it);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid        = 1'b1;
        req_ch.cmd          = it.cmd;
        req_ch.req_size     = it.req_size;
        req_ch.alignment    = it.alignment;
        req_ch.free_address = it.free_address;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        pending_results.push_back(predict_item(it));
    endtask

    function automatic alloc_req_t make_req(logic [CMD_W-1:0] cmd, int unsigned size,
                                            int unsigned align, int unsigned faddr);
        alloc_req_t it;
        it.cmd          = cmd;
        it.req_size     = SIZE_W'(size);
        it.alignment    = ALIGN_W'(align);
        it.free_address = FADDR_W'(faddr);
        return it;
    endfunction

    // address of the live record k entries below the top (random if none)
    function automatic int unsigned live_address(int k);
        if (live_q > k)
            return rec_aligned[live_q - 1 - k][ADDR_BITS-1:0];
        return $urandom_range(0, 65535);
    endfunction

    // drop valid before the core is idle again so the last item is not taken twice
    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        @(negedge clk);
        wr_en    = 1'b1;
        wr_index = idx;
        wr_data  = CFG_DATA_W'(value);
        if (idx == REG_REGION_BASE)
            mirror_base = BASE_W'(value);
        else
            mirror_capacity = CFG_DATA_W'(value);
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    // Registers only change with the core idle; a release then makes the new
    // base the top of the stack.
    task automatic configure_region(int unsigned base, int unsigned capacity);
        wait_drained();
        write_register(REG_REGION_BASE, base);
        write_register(REG_REGION_SIZE, capacity);
        send_request(make_req(CMD_RELEASE, $urandom_range(0, 131071), $urandom_range(0, 255),
                              $urandom_range(0, 65535)));
    endtask

    function automatic int unsigned rand_alignment();
        if ($urandom_range(99) < 75)
            return 1 << $urandom_range(0, 7);
        return $urandom_range(0, 255);
    endfunction

    function automatic int unsigned rand_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 78)
            return $urandom_range(0, 300);
        if (pick < 92)
            return $urandom_range(0, 4096);
        if (pick < 99)
            return $urandom_range(0, 65535);
        return 65536;
    endfunction

    // Mostly allocations and frees of live addresses so the stack gets deep;
    // the rest is bad frees, releases and the ignored code.
    function automatic alloc_req_t random_item();
        alloc_req_t it;
        int         pick;
        it   = make_req(CMD_ALLOC, rand_size(), rand_alignment(), $urandom_range(0, 65535));
        pick = $urandom_range(99);
        if (pick >= 55 && pick < 86)
        begin
            it.cmd = CMD_FREE;
            if (live_q > 0)
                it.free_address = ($urandom_range(99) < 60) ? live_address(0)
                                : live_address($urandom_range(0, live_q - 1));
        end
        else if (pick >= 86 && pick < 92)
            it.cmd = CMD_FREE;
        else if (pick >= 92 && pick < 97)
            it.cmd = CMD_RELEASE;
        else if (pick >= 97)
            it.cmd = CMD_UNUSED;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // straight out of reset: ignored code, free on an empty stack, release
    task automatic test_idle_commands();
        send_request(make_req(CMD_UNUSED, 131071, 255, 65535));
        send_request(make_req(CMD_FREE, 0, 0, 0));
        send_request(make_req(CMD_RELEASE, 0, 0, 0));
    endtask

    task automatic test_alloc_free_directed();
        send_request(make_req(CMD_ALLOC, 0, 0, 65535));       // zero size, zero alignment
        send_request(make_req(CMD_ALLOC, 1, 255, 0));         // odd alignment -> 128
        send_request(make_req(CMD_ALLOC, 65536, 1, 0));       // too large
        send_request(make_req(CMD_ALLOC, 5, 3, 0));
        send_request(make_req(CMD_ALLOC, 100, 128, 0));
        send_request(make_req(CMD_ALLOC, 7, 64, 0));
        send_request(make_req(CMD_FREE, 0, 0, live_address(0)));    // top entry
        send_request(make_req(CMD_ALLOC, 33, 16, 0));
        send_request(make_req(CMD_ALLOC, 2, 8, 0));
        send_request(make_req(CMD_FREE, 0, 0, live_address(3)));    // pops records above too
        send_request(make_req(CMD_FREE, 0, 0, 16'hABCD));          // unknown address
        send_request(make_req(CMD_ALLOC, 17'h0AAAA, 128, 0));
        send_request(make_req(CMD_ALLOC, 17'h05555, 32, 16'h5555));
        // hold off until the core has answered everything
        wait_drained();
        send_request(make_req(CMD_ALLOC, 17'h15555, 2, 0));
        send_request(make_req(CMD_RELEASE, 17'h1FFFF, 255, 65535));
        send_request(make_req(CMD_ALLOC, 65536 - HEADER_BYTES, 1, 0)); // fills exactly
        send_request(make_req(CMD_ALLOC, 0, 1, 0));                    // no room left
        send_request(make_req(CMD_FREE, 0, 0, live_address(0)));
        send_request(make_req(CMD_FREE, 0, 0, HEADER_BYTES));          // already gone
        send_request(make_req(CMD_UNUSED, 0, 0, 0));
    endtask

    // fill every record slot, then two more, then unwind part way
    task automatic test_stack_full();
        send_request(make_req(CMD_RELEASE, 0, 0, 0));
        for (int n = 0; n < STACK_DEPTH + 2; n++)
            send_request(make_req(CMD_ALLOC, $urandom_range(0, 20), 1 << $urandom_range(0, 4),
                                  $urandom_range(0, 65535)));
        send_request(make_req(CMD_FREE, 0, 0, live_address(STACK_DEPTH / 2)));
        send_request(make_req(CMD_ALLOC, 9, 4, 0));
        send_request(make_req(CMD_FREE, 0, 0, live_address(0)));
    endtask

    task automatic test_region_config();
        // base at the top of the space: grants wrap past ADDR_BITS
        configure_region(16'hFFFF, 65536);
        send_request(make_req(CMD_ALLOC, 10, 16, 0));
        send_request(make_req(CMD_ALLOC, 3, 128, 0));
        send_request(make_req(CMD_FREE, 0, 0, live_address(1)));
        // new base stays pending until the next release
        wait_drained();
        write_register(REG_REGION_BASE, 16'h1234);
        send_request(make_req(CMD_ALLOC, 4, 8, 0));
        send_request(make_req(CMD_RELEASE, 0, 0, 0));
        send_request(make_req(CMD_ALLOC, 4, 8, 0));
        // smallest capacity: even a header does not fit
        configure_region(0, 1);
        send_request(make_req(CMD_ALLOC, 0, 1, 0));
        // exactly one header's worth
        configure_region(0, HEADER_BYTES);
        send_request(make_req(CMD_ALLOC, 0, 1, 0));
        send_request(make_req(CMD_ALLOC, 0, 1, 0));
    endtask

    task automatic test_random_traffic(int unsigned base, int unsigned capacity, int count,
                                       bit with_idle);
        configure_region(base, capacity);
        idle_on = with_idle;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 2)
                wait_drained();
            send_request(random_item());
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n               = 1'b0;
        wr_en               = 1'b0;
        wr_index            = REG_REGION_BASE;
        wr_data             = '0;
        req_ch.valid        = 1'b0;
        req_ch.cmd          = CMD_ALLOC;
        req_ch.req_size     = '0;
        req_ch.alignment    = '0;
        req_ch.free_address = '0;
        errors              = 0;
        cycle_count         = 0;
        idle_on             = 1'b1;
        mirror_base         = '0;
        mirror_capacity     = REGION_SIZE_RESET;
        empty_mirror();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_idle_commands();
        test_alloc_free_directed();
        test_stack_full();
        test_region_config();
        test_random_traffic(0, 65536, 400, 1'b1);
        test_random_traffic($urandom_range(0, 65535), $urandom_range(256, 65536), 300, 1'b1);
        test_random_traffic(16'hFFFF, 65536, 300, 1'b0);   // no idling on either side
        test_random_traffic($urandom_range(0, 65535), $urandom_range(1024, 4096), 250, 1'b1);
        test_random_traffic(0, 65536, 200, 1'b1);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
